// ----- src/sbphm_pkg.sv -----
// package for the spectrum bar peak-hold meter
// widths, register indexes, reset values and the item type shared by all modules
// no dependencies
package sbphm_pkg;

    localparam int BAR_W      = 5;
    localparam int MAG_W      = 16;
    localparam int TIME_W     = 32;
    localparam int HGT_W      = 7;
    localparam int HOLD_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam int NUM_BARS_DEF = 32;

    // product of magnitude and (max - 1), and the quotient by full scale
    localparam int PROD_W = MAG_W + HGT_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int QUO_W  = 14;
    localparam int MAG_FULL_SCALE = 1023;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_BAR_HEIGHT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_INTERVAL_MS = 1'd1;

    localparam logic [HGT_W-1:0]  MAX_BAR_HEIGHT_RST   = 7'd16;
    localparam logic [HOLD_W-1:0] HOLD_INTERVAL_MS_RST = 16'd50;

    typedef struct packed {
        logic [BAR_W-1:0]  bar_index;
        logic [HGT_W-1:0]  height;
        logic              redlined;
        logic [TIME_W-1:0] now_ms;
    } t_bar_item;

endpackage

// ----- src/sbphm_height.sv -----
// bar height mapping pipeline: input register, product, quotient by full scale, clamp
// and redline flag; depends on sbphm_pkg
module sbphm_height (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sbphm_pkg::HGT_W-1:0]      i_max,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [sbphm_pkg::BAR_W-1:0]      i_bar_index,
    input  logic [sbphm_pkg::MAG_W-1:0]      i_magnitude,
    input  logic [sbphm_pkg::TIME_W-1:0]     i_now_ms,
    output logic                             o_valid,
    input  logic                             i_ready,
    output sbphm_pkg::t_bar_item             o_item
);

    localparam int PROD_W = sbphm_pkg::PROD_W;
    localparam int SUM_W  = sbphm_pkg::SUM_W;
    localparam int QUO_W  = sbphm_pkg::QUO_W;
    localparam int HGT_W  = sbphm_pkg::HGT_W;
    localparam int RED_W  = HGT_W + 3;

    logic                             r_v1, r_v2, r_v3, r_v4;
    logic                             en1, en2, en3, en4;

    logic [sbphm_pkg::BAR_W-1:0]      r_s1_idx, r_s2_idx, r_s3_idx;
    logic [sbphm_pkg::MAG_W-1:0]      r_s1_mag;
    logic [sbphm_pkg::TIME_W-1:0]     r_s1_now, r_s2_now, r_s3_now;
    logic [PROD_W-1:0]                r_s2_prod;
    logic [QUO_W-1:0]                 r_s3_quo;
    sbphm_pkg::t_bar_item             r_s4;

    logic [PROD_W-1:0]                n_prod;
    logic [SUM_W-1:0]                 w_sum;
    logic [QUO_W-1:0]                 w_quo_est;
    logic [SUM_W-1:0]                 w_rem;
    logic [QUO_W-1:0]                 n_quo;
    logic [QUO_W-1:0]                 w_hgt_raw;
    logic [HGT_W-1:0]                 n_height;
    logic                             n_redlined;

    // stall chain from the output back to the input
    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    assign n_prod = PROD_W'(i_max - 7'd1) * PROD_W'(r_s1_mag);

    // divide by 1023: p/1024 * (1 + 2^-10 + 2^-20) undershoots by at most one
    assign w_sum     = SUM_W'(r_s2_prod) + SUM_W'(r_s2_prod >> 10) + SUM_W'(r_s2_prod >> 20);
    assign w_quo_est = QUO_W'(w_sum >> 10);
    assign w_rem     = SUM_W'(r_s2_prod)
                     - SUM_W'(w_quo_est) * SUM_W'(sbphm_pkg::MAG_FULL_SCALE);
    assign n_quo     = (w_rem >= SUM_W'(sbphm_pkg::MAG_FULL_SCALE)) ? w_quo_est + QUO_W'(1)
                                                                     : w_quo_est;

    assign w_hgt_raw  = r_s3_quo + QUO_W'(1);
    assign n_height   = (w_hgt_raw > QUO_W'(i_max)) ? i_max : w_hgt_raw[HGT_W-1:0];
    assign n_redlined = (RED_W'(n_height) * RED_W'(5)) > (RED_W'(i_max) * RED_W'(3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_s1_idx <= i_bar_index;
            r_s1_mag <= i_magnitude;
            r_s1_now <= i_now_ms;
        end
        if (en2 && r_v1) begin
            r_s2_idx  <= r_s1_idx;
            r_s2_prod <= n_prod;
            r_s2_now  <= r_s1_now;
        end
        if (en3 && r_v2) begin
            r_s3_idx <= r_s2_idx;
            r_s3_quo <= n_quo;
            r_s3_now <= r_s2_now;
        end
        if (en4 && r_v3) begin
            r_s4.bar_index <= r_s3_idx;
            r_s4.height    <= n_height;
            r_s4.redlined  <= n_redlined;
            r_s4.now_ms    <= r_s3_now;
        end
    end

    assign o_valid = r_v4;
    assign o_item  = r_s4;

    a_height_bounds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_s4.height >= HGT_W'(1)) && (r_s4.height <= i_max))
        else $error("bar height outside 1..max");

    a_stall_keeps_stage : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !en3 |=> r_v2 && $stable(r_s2_prod))
        else $error("stalled product stage lost its contents");

endmodule

// ----- src/sbphm_peak.sv -----
// per-bar peak hold state with read-modify-write and the result register
// depends on sbphm_pkg
module sbphm_peak #(
    parameter int NUM_BARS = sbphm_pkg::NUM_BARS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sbphm_pkg::HOLD_W-1:0]     i_hold_interval_ms,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  sbphm_pkg::t_bar_item             i_item,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [sbphm_pkg::BAR_W-1:0]      o_out_bar_index,
    output logic [sbphm_pkg::HGT_W-1:0]      o_bar_height,
    output logic [sbphm_pkg::HGT_W-1:0]      o_peak_level,
    output logic                             o_redlined
);

    localparam int BAR_W   = sbphm_pkg::BAR_W;
    localparam int HGT_W   = sbphm_pkg::HGT_W;
    localparam int TIME_W  = sbphm_pkg::TIME_W;
    localparam int ADDR_SPAN = 2 ** BAR_W;
    // bars beyond what the index field can reach never need storage
    localparam int DEPTH   = (NUM_BARS < ADDR_SPAN) ? NUM_BARS : ADDR_SPAN;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RANGE_W = BAR_W + 2;

    logic [HGT_W-1:0]   r_held  [DEPTH];
    logic [TIME_W-1:0]  r_stamp [DEPTH];

    logic               r_out_valid;
    logic [BAR_W-1:0]   r_out_idx;
    logic [HGT_W-1:0]   r_out_height;
    logic [HGT_W-1:0]   r_out_peak;
    logic               r_out_red;

    logic               w_take;
    logic               w_in_range;
    logic [IDX_W-1:0]   w_idx;
    logic [HGT_W-1:0]   w_old_peak;
    logic [TIME_W-1:0]  w_old_stamp;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_decay;
    logic [HGT_W-1:0]   n_peak;
    logic [TIME_W-1:0]  n_stamp;

    assign o_ready    = !r_out_valid || i_ready;
    assign w_take     = i_valid && o_ready;
    assign w_in_range = RANGE_W'(i_item.bar_index) < RANGE_W'(NUM_BARS);
    assign w_idx      = i_item.bar_index[IDX_W-1:0];

    assign w_old_peak  = w_in_range ? r_held[w_idx]  : '0;
    assign w_old_stamp = w_in_range ? r_stamp[w_idx] : '0;
    // wrapping difference of the millisecond clock
    assign w_elapsed   = i_item.now_ms - w_old_stamp;
    assign w_decay     = (w_elapsed > TIME_W'(i_hold_interval_ms))
                       && (w_old_peak > i_item.height);

    always_comb begin
        n_peak  = w_old_peak;
        n_stamp = w_old_stamp;
        if (i_item.height > w_old_peak) begin
            n_peak  = i_item.height;
            n_stamp = i_item.now_ms;
        end else if (w_decay) begin
            n_peak  = w_old_peak - HGT_W'(1);
            n_stamp = i_item.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_held[k]  <= '0;
                r_stamp[k] <= '0;
            end
        end else if (w_take && w_in_range) begin
            r_held[w_idx]  <= n_peak;
            r_stamp[w_idx] <= n_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_idx    <= i_item.bar_index;
            r_out_height <= i_item.height;
            r_out_peak   <= w_in_range ? n_peak : '0;
            r_out_red    <= i_item.redlined;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_bar_index = r_out_idx;
    assign o_bar_height    = r_out_height;
    assign o_peak_level    = r_out_peak;
    assign o_redlined      = r_out_red;

    a_unknown_bar_no_peak : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && !w_in_range |=> r_out_peak == '0)
        else $error("request for a bar without storage reported a peak");

    a_peak_not_below_bar : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && w_in_range |=> r_out_peak >= r_out_height)
        else $error("held peak below current bar height");

endmodule

// ----- src/spectrum_bar_peak_hold_meter_unit.sv -----
// an accepted request passes the four-stage height pipeline, then the peak
// update stage that loads the result register and drives o_valid; throughput: one
// request per cycle unless i_ready stalls; the per-bar peak and stamp are read,
// updated and written back in the same cycle, so the same bar may follow itself directly
// reset: synchronous, active low; clears all pipeline valids, every held peak and
// stamp to zero, max bar height to 16 and hold interval to 50 ms
module spectrum_bar_peak_hold_meter_unit #(
    parameter int NUM_BARS = sbphm_pkg::NUM_BARS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [sbphm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sbphm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [sbphm_pkg::BAR_W-1:0]           i_bar_index,
    input  logic [sbphm_pkg::MAG_W-1:0]           i_magnitude,
    input  logic [sbphm_pkg::TIME_W-1:0]          i_now_ms,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [sbphm_pkg::BAR_W-1:0]           o_out_bar_index,
    output logic [sbphm_pkg::HGT_W-1:0]           o_bar_height,
    output logic [sbphm_pkg::HGT_W-1:0]           o_peak_level,
    output logic                                  o_redlined
);

    localparam int HGT_W  = sbphm_pkg::HGT_W;
    localparam int HOLD_W = sbphm_pkg::HOLD_W;

    logic [HGT_W-1:0]       r_max_bar_height;
    logic [HOLD_W-1:0]      r_hold_interval_ms;
    logic [HGT_W-1:0]       w_max_eff;

    logic                   w_mid_valid;
    logic                   w_mid_ready;
    sbphm_pkg::t_bar_item   w_mid_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bar_height   <= sbphm_pkg::MAX_BAR_HEIGHT_RST;
            r_hold_interval_ms <= sbphm_pkg::HOLD_INTERVAL_MS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                sbphm_pkg::REG_MAX_BAR_HEIGHT: begin
                    r_max_bar_height <= i_cfg_data[HGT_W-1:0];
                end
                sbphm_pkg::REG_HOLD_INTERVAL_MS: begin
                    r_hold_interval_ms <= i_cfg_data[HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // a zero max behaves as one
    assign w_max_eff = (r_max_bar_height == '0) ? HGT_W'(1) : r_max_bar_height;

    sbphm_height u_height (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max       (w_max_eff),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_bar_index (i_bar_index),
        .i_magnitude (i_magnitude),
        .i_now_ms    (i_now_ms),
        .o_valid     (w_mid_valid),
        .i_ready     (w_mid_ready),
        .o_item      (w_mid_item)
    );

    sbphm_peak #(
        .NUM_BARS (NUM_BARS)
    ) u_peak (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_hold_interval_ms (r_hold_interval_ms),
        .i_valid            (w_mid_valid),
        .o_ready            (w_mid_ready),
        .i_item             (w_mid_item),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_out_bar_index    (o_out_bar_index),
        .o_bar_height       (o_bar_height),
        .o_peak_level       (o_peak_level),
        .o_redlined         (o_redlined)
    );

    a_redline_vs_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (w_max_eff == HGT_W'(1)) |-> o_redlined)
        else $error("bar not redlined at unit full scale");

endmodule
